FILE: sv/conv3_pkg.sv
// ----------------------------------------------------------------------------
// conv3_pkg: shared types and constants of the 3x3 weighted filter
// Pixel, coordinate and configuration widths, window and result types.
// ----------------------------------------------------------------------------
package conv3_pkg;

  localparam int PIX_W        = 8;
  localparam int COORD_W      = 11;
  localparam int DIM_W        = 12;
  localparam int WROW_W       = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int PROD_W       = 2 * PIX_W;
  localparam int SUM_W        = PROD_W + 4;
  localparam int SUM_SHIFT    = 4;
  localparam int PIX_MAX      = 255;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // Results that may be pending between acceptance and delivery.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [DIM_W-1:0]  WIDTH_RST   = 12'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST  = 12'd480;
  localparam logic [WROW_W-1:0] WTOP_RST    = 24'h010201;
  localparam logic [WROW_W-1:0] WMID_RST    = 24'h030403;
  localparam logic [WROW_W-1:0] WBOT_RST    = 24'h010201;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_WEIGHTS_TOP  = 3'd2,
    CFG_WEIGHTS_MID  = 3'd3,
    CFG_WEIGHTS_BOT  = 3'd4
  } cfg_idx_e;

  // [row][col][bit]; col 0 is the left (oldest) column, row 0 the top row.
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic               emit;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } res_t;

endpackage

FILE: sv/conv3_if.sv
// ----------------------------------------------------------------------------
// conv3 stream interfaces
// Valid/ready channels for input pixels and filtered results.
// ----------------------------------------------------------------------------
interface conv3_pix_if;
  import conv3_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface conv3_res_if;
  import conv3_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   filtered_pixel;
  logic [COORD_W-1:0] center_row;
  logic [COORD_W-1:0] center_col;
  logic               frame_last;

  modport source (output valid, output filtered_pixel, output center_row,
                  output center_col, output frame_last, input ready);
  modport sink (input valid, input filtered_pixel, input center_row,
                input center_col, input frame_last, output ready);
endinterface

FILE: sv/conv3_window.sv
// ----------------------------------------------------------------------------
// conv3_window: raster counters, line stores and 3x3 window
// Reads both line stores at the current column on acceptance, writes them
// back in the next cycle and shifts the window by one column.
// ----------------------------------------------------------------------------
module conv3_window #(
  parameter int MaxWidth  = conv3_pkg::MAX_WIDTH_DEF,
  parameter int MaxHeight = conv3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [conv3_pkg::PIX_W-1:0]   pixel_i,
  input  logic [conv3_pkg::DIM_W-1:0]   width_i,
  input  logic [conv3_pkg::DIM_W-1:0]   height_i,
  output logic                          emit_o,
  output conv3_pkg::win_t               win_o,
  output conv3_pkg::tag_t               tag_o
);
  import conv3_pkg::*;

  localparam int CW  = $clog2(MaxWidth);
  localparam int RW  = $clog2(MaxHeight);
  localparam int WXW = ($clog2(MaxWidth + 1) > DIM_W) ? $clog2(MaxWidth + 1) : DIM_W;
  localparam int HXW = ($clog2(MaxHeight + 1) > DIM_W) ? $clog2(MaxHeight + 1) : DIM_W;

  logic [PIX_W-1:0] upper_mem [MaxWidth];
  logic [PIX_W-1:0] lower_mem [MaxWidth];

  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [WXW-1:0]   w_raw, w_eff;
  logic [HXW-1:0]   h_raw, h_eff;
  logic [WXW:0]     col_inc;
  logic [HXW:0]     row_inc;
  logic             row_end, frame_end;

  logic               s1_valid_q, s1_emit_q, s1_last_q;
  logic [CW-1:0]      s1_idx_q;
  logic [PIX_W-1:0]   s1_px_q, up_rd_q, lo_rd_q;
  logic [COORD_W-1:0] s1_row_q, s1_col_q;
  logic               tag_emit_q, tag_last_q;
  logic [COORD_W-1:0] tag_row_q, tag_col_q;
  win_t               win_q;

  always_comb begin
    w_raw = WXW'(width_i);
    if (w_raw < WXW'(3)) begin
      w_eff = WXW'(3);
    end else if (w_raw > WXW'(MaxWidth)) begin
      w_eff = WXW'(MaxWidth);
    end else begin
      w_eff = w_raw;
    end
    h_raw = HXW'(height_i);
    if (h_raw < HXW'(3)) begin
      h_eff = HXW'(3);
    end else if (h_raw > HXW'(MaxHeight)) begin
      h_eff = HXW'(MaxHeight);
    end else begin
      h_eff = h_raw;
    end
  end

  // A counter left beyond the end by a smaller size wraps like a normal end.
  assign col_inc   = (WXW+1)'(col_q) + (WXW+1)'(1);
  assign row_inc   = (HXW+1)'(row_q) + (HXW+1)'(1);
  assign row_end   = col_inc >= (WXW+1)'(w_eff);
  assign frame_end = row_end && (row_inc >= (HXW+1)'(h_eff));
  assign emit_o    = (col_q >= CW'(2)) && (row_q >= RW'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      tag_emit_q <= 1'b0;
      win_q      <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept_i;
      s1_emit_q  <= accept_i && emit_o;
      tag_emit_q <= s1_valid_q && s1_emit_q;
      if (s1_valid_q) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k][0] <= win_q[k][1];
          win_q[k][1] <= win_q[k][2];
        end
        win_q[0][2] <= up_rd_q;
        win_q[1][2] <= lo_rd_q;
        win_q[2][2] <= s1_px_q;
      end
    end
  end

  // Line stores: read on acceptance, written back the following cycle.
  // Consecutive transactions always touch different columns.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      up_rd_q   <= upper_mem[col_q];
      lo_rd_q   <= lower_mem[col_q];
      s1_idx_q  <= col_q;
      s1_px_q   <= pixel_i;
      s1_last_q <= frame_end;
      s1_row_q  <= COORD_W'(row_q - RW'(1));
      s1_col_q  <= COORD_W'(col_q - CW'(1));
    end
    if (s1_valid_q) begin
      upper_mem[s1_idx_q] <= lo_rd_q;
      lower_mem[s1_idx_q] <= s1_px_q;
      tag_last_q          <= s1_last_q;
      tag_row_q           <= s1_row_q;
      tag_col_q           <= s1_col_q;
    end
  end

  assign win_o = win_q;
  assign tag_o = tag_t'{tag_emit_q, tag_last_q, tag_row_q, tag_col_q};

endmodule

FILE: sv/conv3_mac.sv
// ----------------------------------------------------------------------------
// conv3_mac: weighted sum of the 3x3 window
// Registers the nine products, then adds, scales by 1/16 and saturates.
// ----------------------------------------------------------------------------
module conv3_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  conv3_pkg::win_t                     win_i,
  input  conv3_pkg::tag_t                     tag_i,
  input  logic [2:0][2:0][conv3_pkg::PIX_W-1:0] weights_i,
  output logic                                res_valid_o,
  output conv3_pkg::res_t                     res_o
);
  import conv3_pkg::*;

  logic [2:0][2:0][PROD_W-1:0] prod_q;
  logic                        emit_q, last_q;
  logic [COORD_W-1:0]          row_q, col_q;
  logic [SUM_W-1:0]            sum;
  logic [SUM_W-SUM_SHIFT-1:0]  scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
    end else begin
      emit_q <= tag_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= tag_i.last;
    row_q  <= tag_i.row;
    col_q  <= tag_i.col;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[k][j] <= PROD_W'(win_i[k][j]) * PROD_W'(weights_i[k][j]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        sum = sum + SUM_W'(prod_q[k][j]);
      end
    end
    scaled = sum[SUM_W-1:SUM_SHIFT];
    if (scaled > (SUM_W-SUM_SHIFT)'(PIX_MAX)) begin
      res_o.pixel = PIX_W'(PIX_MAX);
    end else begin
      res_o.pixel = scaled[PIX_W-1:0];
    end
    res_o.row  = row_q;
    res_o.col  = col_q;
    res_o.last = last_q;
  end

  assign res_valid_o = emit_q;

endmodule

FILE: sv/conv3_out_fifo.sv
// ----------------------------------------------------------------------------
// conv3_out_fifo: result queue
// Holds finished results until the sink takes them.
// ----------------------------------------------------------------------------
module conv3_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  conv3_pkg::res_t push_data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output conv3_pkg::res_t data_o
);
  import conv3_pkg::*;

  res_t                 mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + OUT_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

endmodule

FILE: sv/conv3x3_weighted_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_weighted_filter: 3x3 weighted convolution over a raster stream
// A result passes the window, tag, product and result queue registers before it is valid.
// Throughput: one pixel per clock; ready falls only while eight results are
// pending, as set by the depth of the result queue.
// Reset restores the default frame size and kernel and clears the counters
// and window; the line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module conv3x3_weighted_filter #(
  parameter int MaxWidth  = conv3_pkg::MAX_WIDTH_DEF,
  parameter int MaxHeight = conv3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [conv3_pkg::WROW_W-1:0]      cfg_data_i,
  conv3_pix_if.sink                         pixel_i,
  conv3_res_if.source                       result_o
);
  import conv3_pkg::*;

  logic [DIM_W-1:0]             width_q, height_q;
  logic [2:0][2:0][PIX_W-1:0]   weights_q;
  logic [OUT_CNT_W-1:0]         pend_q;
  logic                         accept, emit, pop;
  win_t                         win;
  tag_t                         tag;
  logic                         res_valid;
  res_t                         res, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= WIDTH_RST;
      height_q     <= HEIGHT_RST;
      weights_q[0] <= WTOP_RST;
      weights_q[1] <= WMID_RST;
      weights_q[2] <= WBOT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q      <= cfg_data_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_q     <= cfg_data_i[DIM_W-1:0];
        CFG_WEIGHTS_TOP:  weights_q[0] <= cfg_data_i;
        CFG_WEIGHTS_MID:  weights_q[1] <= cfg_data_i;
        CFG_WEIGHTS_BOT:  weights_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Count results that are promised but not yet delivered, so the queue
  // can never overflow whatever the sink does.
  assign accept        = pixel_i.valid && pixel_i.ready;
  assign pop           = result_o.valid && result_o.ready;
  assign pixel_i.ready = pend_q < OUT_CNT_W'(OUT_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if ((accept && emit) && !pop) begin
      pend_q <= pend_q + OUT_CNT_W'(1);
    end else if (pop && !(accept && emit)) begin
      pend_q <= pend_q - OUT_CNT_W'(1);
    end
  end

  conv3_window #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .pixel_i  (pixel_i.pixel_in),
    .width_i  (width_q),
    .height_i (height_q),
    .emit_o   (emit),
    .win_o    (win),
    .tag_o    (tag)
  );

  conv3_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (win),
    .tag_i       (tag),
    .weights_i   (weights_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  conv3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (pop),
    .valid_o     (result_o.valid),
    .data_o      (head)
  );

  assign result_o.filtered_pixel = head.pixel;
  assign result_o.center_row     = head.row;
  assign result_o.center_col     = head.col;
  assign result_o.frame_last     = head.last;

endmodule
